// File: rtl/core/rcp_pkg.sv
// Shared types and constants for the rgb color token parser.
package rcp_pkg;

  localparam int unsigned MAX_DIGITS = 3;

  localparam logic [7:0] CH_R      = 8'h72;  // 'r'
  localparam logic [7:0] CH_G      = 8'h67;  // 'g'
  localparam logic [7:0] CH_B      = 8'h62;  // 'b'
  localparam logic [7:0] CH_LPAREN = 8'h28;  // '('
  localparam logic [7:0] CH_COMMA  = 8'h2C;  // ','
  localparam logic [7:0] CH_RPAREN = 8'h29;  // ')'
  localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE   = 8'h39;  // '9'
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam logic [23:0] WINDOW_RGB = {CH_R, CH_G, CH_B};
  localparam logic [9:0]  COMP_MAX   = 10'd255;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [5:0] {
    PH_SEARCH = 6'b000001,
    PH_RED    = 6'b000010,
    PH_GREEN  = 6'b000100,
    PH_BLUE   = 6'b001000,
    PH_OK     = 6'b010000,
    PH_ERR    = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic        status;
    logic [23:0] color;
  } out_word_t;

endpackage

// File: rtl/core/rgb_color_token_parser.sv
// Top level of the rgb color token parser: input register, parser, result register.
//
// Usage: feed a string one byte per input word on in_data (text_byte plus
// end_of_text on the last byte). The block looks for the first "rgb(" and
// parses three decimal components closed by ')'. Exactly one result word
// leaves on out_data for each string, on its end_of_text byte: status 0 with
// the packed 0xRRGGBB color, or status 1 with color zero.
// An accepted word is held in the input register and parsed from there; the
// result word for an end_of_text byte is loaded into the result register when
// that byte advances.
// Throughput: one byte per cycle while no end_of_text byte waits on a full
// result register; bytes that are not end_of_text never wait on the output.
// Reset (rst_n low, synchronous) empties both registers and returns the
// parser to searching. When out_stall holds the result, the input register
// still takes words; an end_of_text byte then waits in it and in_stall rises
// until the result word is taken.
module rgb_color_token_parser
  import rcp_pkg::*;
#(
  parameter int unsigned COMP_DIGITS = MAX_DIGITS
)
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  logic      in_valid_r;
  in_word_t  in_word_r;
  logic      out_valid_r;
  out_word_t out_word_r;

  logic      out_free;
  logic      advance;
  out_word_t step_result;

  // Output slot is free when empty or being emptied this cycle.
  assign out_free = !out_valid_r || !out_stall;
  // Advance the buffered byte unless it ends the text and the slot is full.
  assign advance  = in_valid_r && (!in_word_r.end_of_text || out_free);
  // Hold the input while a buffered byte cannot advance.
  assign in_stall = in_valid_r && !advance;

  rcp_parse #(
    .COMP_DIGITS (COMP_DIGITS)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .word    (in_word_r),
    .result  (step_result)
  );

  // Input register: refill whenever it is not held.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_word_r <= in_data;
    end
  end

  // Result register: load on an advancing end_of_text byte, drop when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && in_word_r.end_of_text) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_word_r.end_of_text) begin
      out_word_r <= step_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule

// File: rtl/core/rcp_parse.sv
// Parser state and per-byte next-state logic for the rgb color token parser.
module rcp_parse
  import rcp_pkg::*;
#(
  parameter int unsigned COMP_DIGITS = MAX_DIGITS
)
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  in_word_t  word,
  output out_word_t result
);

  phase_t      phase_r,   phase_nxt;
  logic [23:0] recent_r,  recent_nxt;
  logic [1:0]  dcount_r,  dcount_nxt;
  logic [9:0]  acc_r,     acc_nxt;
  logic [9:0]  red_r,     red_nxt;
  logic [9:0]  green_r,   green_nxt;
  logic [23:0] packed_r,  packed_nxt;

  logic [7:0]  c;
  logic        is_digit;
  logic [9:0]  digit_val;
  logic [9:0]  acc_step;

  assign c         = word.text_byte;
  assign is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
  assign digit_val = {2'b00, c - CH_ZERO};
  // acc * 10 + digit, kept to 10 bits
  assign acc_step  = {acc_r[6:0], 3'b000} + {acc_r[8:0], 1'b0} + digit_val;

  always_comb begin
    phase_nxt  = phase_r;
    recent_nxt = recent_r;
    dcount_nxt = dcount_r;
    acc_nxt    = acc_r;
    red_nxt    = red_r;
    green_nxt  = green_r;
    packed_nxt = packed_r;
    case (phase_r)
      PH_SEARCH: begin
        if (c == CH_NUL) begin
          phase_nxt = PH_ERR;
        end else if (c == CH_LPAREN && recent_r == WINDOW_RGB) begin
          phase_nxt  = PH_RED;
          dcount_nxt = 2'd0;
          acc_nxt    = 10'd0;
        end else begin
          recent_nxt = {recent_r[15:0], c};
        end
      end
      PH_RED, PH_GREEN, PH_BLUE: begin
        if (is_digit) begin
          if (32'(dcount_r) >= COMP_DIGITS) begin
            phase_nxt = PH_ERR;
          end else begin
            acc_nxt    = acc_step;
            dcount_nxt = dcount_r + 2'd1;
          end
        end else if (dcount_r == 2'd0) begin
          phase_nxt = PH_ERR;
        end else if (phase_r != PH_BLUE) begin
          if (c != CH_COMMA) begin
            phase_nxt = PH_ERR;
          end else begin
            if (phase_r == PH_RED) begin
              red_nxt   = acc_r;
              phase_nxt = PH_GREEN;
            end else begin
              green_nxt = acc_r;
              phase_nxt = PH_BLUE;
            end
            dcount_nxt = 2'd0;
            acc_nxt    = 10'd0;
          end
        end else if (c != CH_RPAREN || red_r > COMP_MAX || green_r > COMP_MAX
                     || acc_r > COMP_MAX) begin
          phase_nxt = PH_ERR;
        end else begin
          packed_nxt = {red_r[7:0], green_r[7:0], acc_r[7:0]};
          phase_nxt  = PH_OK;
        end
      end
      default: begin
        // outcome settled: drop bytes until the end of the text
      end
    endcase
  end

  always_comb begin
    if (phase_nxt == PH_OK) begin
      result.status = STATUS_OK;
      result.color  = packed_nxt;
    end else begin
      result.status = STATUS_ERR;
      result.color  = 24'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step_en && word.end_of_text)) begin
      phase_r  <= PH_SEARCH;
      recent_r <= 24'd0;
      dcount_r <= 2'd0;
      acc_r    <= 10'd0;
      red_r    <= 10'd0;
      green_r  <= 10'd0;
      packed_r <= 24'd0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      recent_r <= recent_nxt;
      dcount_r <= dcount_nxt;
      acc_r    <= acc_nxt;
      red_r    <= red_nxt;
      green_r  <= green_nxt;
      packed_r <= packed_nxt;
    end
  end

endmodule

// File: dv/rgb_color_token_parser_tb.sv
// Self-checking testbench for the rgb color token parser: directed and random strings.
`timescale 1ns / 100ps

import rcp_pkg::*;

class color_scoreboard;
  phase_t      phase;
  logic [23:0] window;
  int unsigned ndigits;
  logic [9:0]  acc;
  logic [9:0]  red;
  logic [9:0]  green;
  logic [23:0] rgb_word;
  out_word_t   pending[$];
  int unsigned errors;

  function new();
    errors = 0;
    clear();
  endfunction

  function void clear();
    phase    = PH_SEARCH;
    window   = '0;
    ndigits  = 0;
    acc      = '0;
    red      = '0;
    green    = '0;
    rgb_word = '0;
  endfunction

  // Advance the parser by one accepted byte; queue a result on end_of_text.
  function void note_input(in_word_t w);
    logic [7:0] c;
    out_word_t  exp_word;
    c = w.text_byte;
    case (phase)
      PH_SEARCH: begin
        if (c == CH_NUL) begin
          phase = PH_ERR;
        end else if (c == CH_LPAREN && window == WINDOW_RGB) begin
          phase   = PH_RED;
          ndigits = 0;
          acc     = '0;
        end else begin
          window = {window[15:0], c};
        end
      end
      PH_RED, PH_GREEN, PH_BLUE: begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          if (ndigits >= MAX_DIGITS) begin
            phase = PH_ERR;
          end else begin
            acc = 10'(int'(acc) * 10 + int'(c - CH_ZERO));
            ndigits++;
          end
        end else if (ndigits == 0) begin
          phase = PH_ERR;
        end else if (phase != PH_BLUE) begin
          if (c != CH_COMMA) begin
            phase = PH_ERR;
          end else begin
            if (phase == PH_RED) begin
              red   = acc;
              phase = PH_GREEN;
            end else begin
              green = acc;
              phase = PH_BLUE;
            end
            ndigits = 0;
            acc     = '0;
          end
        end else if (c != CH_RPAREN || red > COMP_MAX || green > COMP_MAX
                     || acc > COMP_MAX) begin
          phase = PH_ERR;
        end else begin
          rgb_word = {red[7:0], green[7:0], acc[7:0]};
          phase    = PH_OK;
        end
      end
      default: ;
    endcase
    if (w.end_of_text) begin
      if (phase == PH_OK) begin
        exp_word.status = STATUS_OK;
        exp_word.color  = rgb_word;
      end else begin
        exp_word.status = STATUS_ERR;
        exp_word.color  = '0;
      end
      pending.push_back(exp_word);
      clear();
    end
  endfunction

  // Compare one result word with the oldest pending color.
  function void check_result(out_word_t got);
    out_word_t exp_word;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result word status %0b color %06h", $time, got.status,
               got.color);
      errors++;
    end else begin
      exp_word = pending.pop_front();
      if (got.status !== exp_word.status) begin
        $display("%0t: status mismatch, expected %0b actual %0b", $time, exp_word.status,
                 got.status);
        errors++;
      end
      if (got.color !== exp_word.color) begin
        $display("%0t: color mismatch, expected %06h actual %06h", $time, exp_word.color,
                 got.color);
        errors++;
      end
    end
  endfunction
endclass

module rgb_color_token_parser_tb;
  import rcp_pkg::*;

  typedef logic [7:0] char_t;

  // Cycle budget: roughly 1.2k bytes, worst gaps and stalls, many times over.
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  color_scoreboard sb;
  char_t           txt[$];          // string being assembled for the next send
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     cycles = 0;

  rgb_color_token_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: drop the run if it hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: check every accepted word, then pick the next stall at random.
  // Values read here are the ones from before the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_data);
    end
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      txt.push_back(char_t'(s[i]));
    end
  endfunction

  // Send the assembled string, one word per byte, end_of_text on the last.
  // Hold valid and payload until the word is taken; insert idle cycles at random.
  task automatic send_text();
    in_word_t w;
    for (int i = 0; i < txt.size(); i++) begin
      while ($urandom_range(0, 99) < send_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      w.text_byte   = txt[i];
      w.end_of_text = (i == txt.size() - 1);
      in_valid <= 1'b1;
      in_data  <= w;
      @(posedge clk);
      while (in_stall) begin
        @(posedge clk);
      end
      sb.note_input(w);
    end
    txt.delete();
  endtask

  // Random strings: mostly well-formed colors with random content, some noise,
  // and some with one byte corrupted, dropped, added, or the tail cut off.
  task automatic run_random(input int unsigned byte_budget);
    int unsigned sent_bytes;
    int unsigned kind;
    int unsigned v;
    int unsigned len;
    int unsigned nd;
    int unsigned pos;
    int unsigned scale;
    char_t       b;
    sent_bytes = 0;
    while (sent_bytes < byte_budget) begin
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        repeat ($urandom_range(1, 8)) txt.push_back(char_t'($urandom_range(0, 255)));
      end else begin
        // Junk or near-misses ahead of the real match.
        repeat ($urandom_range(0, 3)) begin
          case ($urandom_range(0, 3))
            0:       txt.push_back(char_t'($urandom_range(1, 255)));
            1:       add_text("rg");
            2:       add_text("rgb");
            default: add_text(" ");
          endcase
        end
        add_text("rgb(");
        for (int k = 0; k < 3; k++) begin
          v   = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 255) : $urandom_range(256, 999);
          len = (v >= 100) ? 3 : (v >= 10) ? 2 : 1;
          nd  = $urandom_range(len, 3);   // allow leading zeros
          for (int d = nd - 1; d >= 0; d--) begin
            scale = (d == 2) ? 100 : (d == 1) ? 10 : 1;
            txt.push_back(CH_ZERO + char_t'((v / scale) % 10));
          end
          txt.push_back((k < 2) ? CH_COMMA : CH_RPAREN);
        end
        // Trailing bytes after the outcome is settled, sometimes a second color.
        case ($urandom_range(0, 3))
          0:       add_text("rgb(1,2,3)");
          1:       repeat ($urandom_range(1, 3)) txt.push_back(char_t'($urandom_range(0, 255)));
          default: ;
        endcase
        if (kind >= 72) begin
          pos = $urandom_range(0, txt.size() - 1);
          case ($urandom_range(0, 4))
            0:       b = CH_ZERO + char_t'($urandom_range(0, 9));
            1:       b = CH_COMMA;
            2:       b = CH_RPAREN;
            3:       b = CH_LPAREN;
            default: b = char_t'($urandom_range(0, 255));
          endcase
          case ($urandom_range(0, 3))
            0: txt[pos] = b;
            1: if (txt.size() > 1) txt.delete(pos);
            2: txt.insert(pos, b);
            default: begin
              while (txt.size() > pos + 1) txt.pop_back();
            end
          endcase
        end
      end
      sent_bytes += txt.size();
      send_text();
    end
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed strings, no idling.
    add_text("rgb(0,0,0)");               send_text();  // smallest color
    add_text("rgb(255,255,255)");         send_text();  // largest color
    add_text("xrgrgb(12,3,200)");         send_text();  // match after a near-miss
    add_text("rgb(1,2,3)rgb(4,5,6)");     send_text();  // later match ignored
    add_text("rgb(256,0,0)");             send_text();  // red above 255
    add_text("rgb(0,0,999)");             send_text();  // blue far above 255
    add_text("rgb(0001,2,3)");            send_text();  // fourth digit
    add_text("rgb(,1,2)");                send_text();  // empty component
    add_text("rgb(1;2,3)");               send_text();  // wrong separator
    add_text("rgb(9,9,9]");               send_text();  // wrong closer
    add_text("rgb(1,2,3");                send_text();  // text ends mid-match
    add_text("rgb(1,2");
    txt.push_back(CH_NUL);                send_text();  // NUL inside a component
    add_text("ab");
    txt.push_back(CH_NUL);
    add_text("rgb(1,2,3)");               send_text();  // NUL while searching
    txt.push_back(8'hFF);
    add_text("rgb(7,8,9)");               send_text();  // high byte before the match
    add_text("q");                        send_text();  // single byte, no match

    // Random phases: no idling, sender idle, receiver stalling, both light.
    run_random(240);
    send_idle_pct = 59;
    run_random(240);
    send_idle_pct  = 0;
    recv_stall_pct = 59;
    run_random(240);
    send_idle_pct  = 9;
    recv_stall_pct = 9;
    run_random(240);
    in_valid <= 1'b0;

    // Drain: wait for every pending color, then a few more edges for strays.
    while (sb.pending.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.pending.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending.size());
    end
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
